// ----- hw/rtl/bgg_pkg.sv -----
package bgg_pkg;

    localparam int POS_W    = 10;
    localparam int SIZE_W   = POS_W + 1;
    localparam int CHAN_W   = 8;
    localparam int RGB_W    = 3 * CHAN_W;
    localparam int PROD_W   = CHAN_W + POS_W;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 5;
    localparam int IDX_W    = 3;
    localparam int STEP_W   = 5;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(PROD_W);

    localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = SIZE_W'(1024);

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);
    localparam logic [RGB_W-1:0]  TL_RST     = 24'hFF0000;
    localparam logic [RGB_W-1:0]  TR_RST     = 24'h0000FF;
    localparam logic [RGB_W-1:0]  BL_RST     = 24'h00FF00;
    localparam logic [RGB_W-1:0]  BR_RST     = 24'hFFFF00;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_TL     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TR     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BL     = 3'd4;
    localparam logic [IDX_W-1:0] REG_BR     = 3'd5;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [RGB_W-1:0]  tl;
        logic [RGB_W-1:0]  tr;
        logic [RGB_W-1:0]  bl;
        logic [RGB_W-1:0]  br;
    } cfg_t;

    typedef struct packed {
        logic adv;
        logic load_edge;
        logic store_edge;
        logic load_row;
        logic step;
        logic emit;
    } cmd_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/bgg_regs.sv -----
module bgg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgg_pkg::PADDR_W-1:0]   paddr,
    input  logic [bgg_pkg::DATA_W-1:0]    pwdata,
    output logic [bgg_pkg::DATA_W-1:0]    prdata,
    output bgg_pkg::cfg_t                 cfg
);

    bgg_pkg::cfg_t                 cfg_reg;
    logic [bgg_pkg::IDX_W-1:0]     idx;
    logic                          wr;

    assign idx = paddr[bgg_pkg::PADDR_W-1:2];
    assign wr  = psel & penable & pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= bgg_pkg::WIDTH_RST;
            cfg_reg.height <= bgg_pkg::HEIGHT_RST;
            cfg_reg.tl     <= bgg_pkg::TL_RST;
            cfg_reg.tr     <= bgg_pkg::TR_RST;
            cfg_reg.bl     <= bgg_pkg::BL_RST;
            cfg_reg.br     <= bgg_pkg::BR_RST;
        end
        else if (wr)
        begin
            case (idx)
                bgg_pkg::REG_WIDTH:  cfg_reg.width  <= pwdata[bgg_pkg::SIZE_W-1:0];
                bgg_pkg::REG_HEIGHT: cfg_reg.height <= pwdata[bgg_pkg::SIZE_W-1:0];
                bgg_pkg::REG_TL:     cfg_reg.tl     <= pwdata[bgg_pkg::RGB_W-1:0];
                bgg_pkg::REG_TR:     cfg_reg.tr     <= pwdata[bgg_pkg::RGB_W-1:0];
                bgg_pkg::REG_BL:     cfg_reg.bl     <= pwdata[bgg_pkg::RGB_W-1:0];
                bgg_pkg::REG_BR:     cfg_reg.br     <= pwdata[bgg_pkg::RGB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bgg_pkg::REG_WIDTH:  prdata = bgg_pkg::DATA_W'(cfg_reg.width);
            bgg_pkg::REG_HEIGHT: prdata = bgg_pkg::DATA_W'(cfg_reg.height);
            bgg_pkg::REG_TL:     prdata = bgg_pkg::DATA_W'(cfg_reg.tl);
            bgg_pkg::REG_TR:     prdata = bgg_pkg::DATA_W'(cfg_reg.tr);
            bgg_pkg::REG_BL:     prdata = bgg_pkg::DATA_W'(cfg_reg.bl);
            bgg_pkg::REG_BR:     prdata = bgg_pkg::DATA_W'(cfg_reg.br);
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/bgg_lerp_lane.sv -----
module bgg_lerp_lane (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [bgg_pkg::CHAN_W-1:0]    a,
    input  logic [bgg_pkg::CHAN_W-1:0]    b,
    input  logic [bgg_pkg::POS_W-1:0]     t,
    input  logic [bgg_pkg::POS_W-1:0]     den,
    output logic [bgg_pkg::CHAN_W-1:0]    res
);

    localparam int PW = bgg_pkg::PROD_W;
    localparam int CW = bgg_pkg::CHAN_W;
    localparam int NW = bgg_pkg::POS_W;

    logic [CW-1:0]        a_reg;
    logic [NW-1:0]        den_reg;
    logic                 neg_reg;
    logic [PW-1:0]        dvd_reg;
    logic [PW-1:0]        dvd_next;
    logic [NW:0]          rem_reg;
    logic [NW:0]          rem_next;
    logic [NW:0]          rem_sh;
    logic                 qbit;
    logic signed [CW:0]   diff;
    logic signed [PW+1:0] prod;
    logic [PW+1:0]        prod_abs;
    logic [CW-1:0]        adj;

    assign diff     = $signed({1'b0, b}) - $signed({1'b0, a});
    assign prod     = (PW+2)'(diff) * (PW+2)'($signed({1'b0, t}));
    assign prod_abs = prod[PW+1] ? (~prod + 1'b1) : prod;

    // restoring division, one quotient bit per step
    always_comb
    begin
        rem_sh = {rem_reg[NW-1:0], dvd_reg[PW-1]};
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = rem_sh - {1'b0, den_reg};
            qbit     = 1'b1;
        end
        else
        begin
            rem_next = rem_sh;
            qbit     = 1'b0;
        end
        dvd_next = {dvd_reg[PW-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg   <= a;
            den_reg <= den;
            neg_reg <= prod[PW+1];
            dvd_reg <= prod_abs[PW-1:0];
            rem_reg <= '0;
        end
        else if (step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    // floor for negative quotients: round the magnitude up when inexact
    assign adj = dvd_reg[CW-1:0] + CW'(neg_reg && (rem_reg != '0));

    always_comb
    begin
        if (den_reg == '0)
        begin
            res = a_reg;
        end
        else if (neg_reg)
        begin
            res = a_reg - adj;
        end
        else
        begin
            res = a_reg + adj;
        end
    end

endmodule

// ----- hw/rtl/bgg_datapath.sv -----
module bgg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bgg_pkg::cfg_t                 cfg,
    input  bgg_pkg::cmd_t                 cmd,
    input  logic                          restart,
    output logic [bgg_pkg::POS_W-1:0]     pix_x,
    output logic [bgg_pkg::POS_W-1:0]     pix_y,
    output logic [bgg_pkg::CHAN_W-1:0]    red,
    output logic [bgg_pkg::CHAN_W-1:0]    green,
    output logic [bgg_pkg::CHAN_W-1:0]    blue,
    output logic                          frame_end
);

    localparam int NW = bgg_pkg::POS_W;
    localparam int SW = bgg_pkg::SIZE_W;
    localparam int CW = bgg_pkg::CHAN_W;

    logic [SW-1:0]  w;
    logic [SW-1:0]  h;
    logic [NW-1:0]  col_reg, col_next;
    logic [NW-1:0]  row_reg, row_next;
    logic [bgg_pkg::RGB_W-1:0] left_edge_reg;
    logic [bgg_pkg::RGB_W-1:0] right_edge_reg;
    logic [bgg_pkg::RGB_W-1:0] left_res;
    logic [bgg_pkg::RGB_W-1:0] right_res;
    logic [SW-1:0]  c0, r0, r1, cp, rp;
    logic [NW-1:0]  den_w;
    logic [NW-1:0]  den_h;
    logic           last;

    logic [NW-1:0]  pix_x_reg;
    logic [NW-1:0]  pix_y_reg;
    logic [CW-1:0]  red_reg, green_reg, blue_reg;
    logic           frame_end_reg;

    assign w     = bgg_pkg::clamp_size(cfg.width, bgg_pkg::MAX_WIDTH);
    assign h     = bgg_pkg::clamp_size(cfg.height, bgg_pkg::MAX_HEIGHT);
    assign den_w = NW'(w - 1'b1);
    assign den_h = NW'(h - 1'b1);

    // position update: wrap before the beat on accept, advance after emit
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        c0 = restart ? '0 : SW'(col_reg);
        r0 = restart ? '0 : SW'(row_reg);
        r1 = r0;
        cp = SW'(col_reg) + 1'b1;
        rp = SW'(row_reg) + 1'b1;
        if (cmd.adv)
        begin
            if (c0 >= w)
            begin
                c0 = '0;
                r1 = r0 + 1'b1;
            end
            if (r1 >= h)
            begin
                r1 = '0;
            end
            col_next = c0[NW-1:0];
            row_next = r1[NW-1:0];
        end
        else if (cmd.emit)
        begin
            if (cp >= w)
            begin
                col_next = '0;
                row_next = (rp >= h) ? '0 : rp[NW-1:0];
            end
            else
            begin
                col_next = cp[NW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_edge_reg  <= bgg_pkg::TL_RST;
            right_edge_reg <= bgg_pkg::TR_RST;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.store_edge)
            begin
                left_edge_reg  <= left_res;
                right_edge_reg <= right_res;
            end
        end
    end

    // lanes for the left edge are reused for the across-row pass
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        logic [CW-1:0] la, lb;
        logic [NW-1:0] lt, lden;

        assign la   = cmd.load_row ? left_edge_reg[ch*CW +: CW]  : cfg.tl[ch*CW +: CW];
        assign lb   = cmd.load_row ? right_edge_reg[ch*CW +: CW] : cfg.bl[ch*CW +: CW];
        assign lt   = cmd.load_row ? col_reg : row_reg;
        assign lden = cmd.load_row ? den_w : den_h;

        bgg_lerp_lane u_left (
            .clk  (clk),
            .load (cmd.load_edge | cmd.load_row),
            .step (cmd.step),
            .a    (la),
            .b    (lb),
            .t    (lt),
            .den  (lden),
            .res  (left_res[ch*CW +: CW])
        );

        bgg_lerp_lane u_right (
            .clk  (clk),
            .load (cmd.load_edge),
            .step (cmd.step),
            .a    (cfg.tr[ch*CW +: CW]),
            .b    (cfg.br[ch*CW +: CW]),
            .t    (row_reg),
            .den  (den_h),
            .res  (right_res[ch*CW +: CW])
        );
    end

    assign last = (SW'(col_reg) == (w - 1'b1)) && (SW'(row_reg) == (h - 1'b1));

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pix_x_reg     <= col_reg;
            pix_y_reg     <= row_reg;
            red_reg       <= left_res[2*CW +: CW];
            green_reg     <= left_res[CW +: CW];
            blue_reg      <= left_res[0 +: CW];
            frame_end_reg <= last;
        end
    end

    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- hw/rtl/bgg_ctrl.sv -----
module bgg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bgg_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_LOAD,
        S_EDGE_DIV,
        S_EDGE_STORE,
        S_ROW_LOAD,
        S_ROW_DIV,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    logic [bgg_pkg::STEP_W-1:0]    cnt_reg;
    logic                          out_valid_reg;
    logic                          emit_ok;
    logic                          last_step;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign last_step = (cnt_reg == bgg_pkg::DIV_STEPS - 1'b1);

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:       cmd.adv        = in_valid;
            S_EDGE_LOAD:  cmd.load_edge  = 1'b1;
            S_EDGE_DIV:   cmd.step       = 1'b1;
            S_EDGE_STORE: cmd.store_edge = 1'b1;
            S_ROW_LOAD:   cmd.load_row   = 1'b1;
            S_ROW_DIV:    cmd.step       = 1'b1;
            S_EMIT:       cmd.emit       = emit_ok;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EDGE_LOAD;
                    end
                end
                S_EDGE_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_EDGE_DIV;
                end
                S_EDGE_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= S_EDGE_STORE;
                    end
                end
                S_EDGE_STORE:
                begin
                    state_reg <= S_ROW_LOAD;
                end
                S_ROW_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ROW_DIV;
                end
                S_ROW_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/bilinear_gradient_generator.sv -----
// Bilinear gradient test-pattern source. Each accepted input beat emits the next pixel of an
// active_width by active_height frame in row-major order, colored by interpolating the four
// corner colors first down the left and right edges and then across the row, with exact
// floor rounding. A beat with restart set begins again at (0,0); frame_end marks the last pixel.
// One pixel goes from acceptance to the output register through two passes of an 18-step
// restoring divider (edges, then the row, three channels each in parallel lanes) plus
// setup, store and emit states; no new beat is taken until the pixel has been emitted and the
// block is idle again. A finished pixel waits in the output register, so the next beat is
// taken while it is still unclaimed. Registers sit on the APB port at byte offsets
// 0x00 width, 0x04 height, 0x08 top left, 0x0C top right, 0x10 bottom left, 0x14 bottom right,
// and should be written only while the block is idle.
module bilinear_gradient_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgg_pkg::PADDR_W-1:0]   paddr,
    input  logic [bgg_pkg::DATA_W-1:0]    pwdata,
    output logic [bgg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bgg_pkg::POS_W-1:0]     pix_x,
    output logic [bgg_pkg::POS_W-1:0]     pix_y,
    output logic [bgg_pkg::CHAN_W-1:0]    red,
    output logic [bgg_pkg::CHAN_W-1:0]    green,
    output logic [bgg_pkg::CHAN_W-1:0]    blue,
    output logic                          frame_end
);

    bgg_pkg::cfg_t cfg;
    bgg_pkg::cmd_t cmd;

    assign pready = 1'b1;

    bgg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bgg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bgg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .restart   (restart),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .frame_end (frame_end)
    );

endmodule

// ----- bench/gradient_checker.sv -----
module gradient_checker
    import bgg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                restart,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [POS_W-1:0]    pix_x,
    input  logic [POS_W-1:0]    pix_y,
    input  logic [CHAN_W-1:0]   red,
    input  logic [CHAN_W-1:0]   green,
    input  logic [CHAN_W-1:0]   blue,
    input  logic                frame_end,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic              frame_end;
    } pixel_t;

    pixel_t      pixels_due[$];
    cfg_t        regs;
    int unsigned col_pos;
    int unsigned row_pos;
    int          mismatch_cnt;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic int unsigned fit_size(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] top);
        int unsigned n;
        n = v;
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > top)
        begin
            n = top;
        end
        return n;
    endfunction

    // a + floor((b - a) * t / (n - 1)), start value for a single-pixel span
    function automatic logic [CHAN_W-1:0] chan_blend(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                                     int unsigned t, int unsigned n);
        int ai;
        int bi;
        int num;
        int den;
        int q;
        if (n <= 1)
        begin
            return a;
        end
        ai  = a;
        bi  = b;
        den = n - 1;
        num = (bi - ai) * int'(t);
        q   = num / den;
        if (num < 0 && q * den != num)
        begin
            q = q - 1;
        end
        return CHAN_W'(ai + q);
    endfunction

    function automatic logic [RGB_W-1:0] rgb_blend(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b,
                                                   int unsigned t, int unsigned n);
        logic [RGB_W-1:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c[i*CHAN_W +: CHAN_W] = chan_blend(a[i*CHAN_W +: CHAN_W], b[i*CHAN_W +: CHAN_W], t, n);
        end
        return c;
    endfunction

    // advances the scan position and returns the pixel for one input beat
    function automatic pixel_t next_pixel(logic restart_bit);
        int unsigned      w;
        int unsigned      h;
        logic [RGB_W-1:0] left_c;
        logic [RGB_W-1:0] right_c;
        logic [RGB_W-1:0] c;
        pixel_t           p;
        w = fit_size(regs.width, MAX_WIDTH);
        h = fit_size(regs.height, MAX_HEIGHT);
        if (restart_bit)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // size may have shrunk since the last pixel
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end
        if (row_pos >= h)
        begin
            row_pos = 0;
        end
        left_c  = rgb_blend(regs.tl, regs.bl, row_pos, h);
        right_c = rgb_blend(regs.tr, regs.br, row_pos, h);
        c       = rgb_blend(left_c, right_c, col_pos, w);
        p.x         = POS_W'(col_pos);
        p.y         = POS_W'(row_pos);
        p.r         = c[2*CHAN_W +: CHAN_W];
        p.g         = c[CHAN_W +: CHAN_W];
        p.b         = c[0 +: CHAN_W];
        p.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
        col_pos = col_pos + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t seen;
        pixel_t want;
        if (!rst_n)
        begin
            regs         = '{WIDTH_RST, HEIGHT_RST, TL_RST, TR_RST, BL_RST, BR_RST};
            col_pos      = 0;
            row_pos      = 0;
            mismatch_cnt = 0;
            pixels_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_WIDTH:  regs.width  = pwdata[SIZE_W-1:0];
                    REG_HEIGHT: regs.height = pwdata[SIZE_W-1:0];
                    REG_TL:     regs.tl     = pwdata[RGB_W-1:0];
                    REG_TR:     regs.tr     = pwdata[RGB_W-1:0];
                    REG_BL:     regs.bl     = pwdata[RGB_W-1:0];
                    REG_BR:     regs.br     = pwdata[RGB_W-1:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                pixels_due.push_back(next_pixel(restart));
            end
            if (out_valid && out_ready)
            begin
                seen = '{pix_x, pix_y, red, green, blue, frame_end};
                if (pixels_due.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("%0t: pixel beat with none due: x=%0d y=%0d rgb=%02h%02h%02h end=%0b",
                                 $realtime, seen.x, seen.y, seen.r, seen.g, seen.b, seen.frame_end);
                    end
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (seen.x != want.x || seen.y != want.y || seen.r != want.r ||
                        seen.g != want.g || seen.b != want.b || seen.frame_end != want.frame_end)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("%0t: pixel wrong: want x=%0d y=%0d rgb=%02h%02h%02h end=%0b",
                                     $realtime, want.x, want.y, want.r, want.g, want.b,
                                     want.frame_end);
                            $display("%0t:              got  x=%0d y=%0d rgb=%02h%02h%02h end=%0b",
                                     $realtime, seen.x, seen.y, seen.r, seen.g, seen.b,
                                     seen.frame_end);
                        end
                    end
                end
            end
        end
        mismatches  <= mismatch_cnt;
        outstanding <= pixels_due.size();
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgg_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PIXELS    = 1800;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 60;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic                restart;
    logic                out_valid;
    logic                out_ready;
    logic [POS_W-1:0]    pix_x;
    logic [POS_W-1:0]    pix_y;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                frame_end;

    int mismatches;
    int outstanding;
    int sent;
    int idle_mode;
    bit long_hold;
    int random_start;

    always #2 clk = ~clk;

    bilinear_gradient_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .frame_end (frame_end)
    );

    gradient_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_end   (frame_end),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // pixel sink: random stalls, plus one long hold so the block backs up
    initial
    begin : sink
        int  hold_left;
        bit  hold_done;
        int  stall_pct;
        hold_left = 0;
        hold_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                hold_done = 1;
                hold_left = LONG_HOLD_CYCLES;
            end
            stall_pct = (idle_mode == 0) ? 66 : (idle_mode == 1) ? 23 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_pixel(bit restart_bit);
        int gap_pct;
        idle_mode = (sent < 600) ? 0 : (sent < 1200) ? 1 : 2;
        gap_pct   = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 66 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sent++;
    endtask

    // wait until every pixel owed has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value, int bits);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        // unused upper bits must be ignored
        if ($urandom_range(0, 1))
        begin
            value = value | (junk & ~((DATA_W'(1) << bits) - 1));
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 12);
        end
        else if (r < 85)
        begin
            return $urandom_range(13, 64);
        end
        else if (r < 90)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(1025, 2047);
        end
        return $urandom_range(65, 1024);
    endfunction

    function automatic logic [DATA_W-1:0] pick_color();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return 0;
        end
        else if (r < 30)
        begin
            return 24'hFFFFFF;
        end
        return $urandom & 32'h00FFFFFF;
    endfunction

    task automatic random_phase();
        bit wrote;
        int n;
        wrote = 0;
        if (sent >= random_start + 700)
        begin
            long_hold = 1;
        end
        for (int i = REG_WIDTH; i <= REG_BR; i++)
        begin
            if ($urandom_range(0, 99) < 60)
            begin
                if (i <= REG_HEIGHT)
                begin
                    reg_write(IDX_W'(i), pick_size(), SIZE_W);
                end
                else
                begin
                    reg_write(IDX_W'(i), pick_color(), RGB_W);
                end
                wrote = 1;
            end
        end
        if (wrote)
        begin
            bus_idle();
        end
        n = $urandom_range(10, 60);
        repeat (n)
        begin
            send_pixel($urandom_range(0, 99) < 4);
        end
        drain();
    endtask

    initial
    begin
        sent      = 0;
        idle_mode = 0;
        long_hold = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        restart  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default geometry and corners after reset
        send_pixel(0);
        send_pixel(0);
        send_pixel(1);
        drain();

        // single-pixel frame with extreme corners: every pixel ends the frame
        reg_write(REG_WIDTH, 1, SIZE_W);
        reg_write(REG_HEIGHT, 1, SIZE_W);
        reg_write(REG_TL, 32'h000000, RGB_W);
        reg_write(REG_TR, 32'hFFFFFF, RGB_W);
        reg_write(REG_BL, 32'hFFFFFF, RGB_W);
        reg_write(REG_BR, 32'h000000, RGB_W);
        bus_idle();
        send_pixel(0);
        send_pixel(0);
        drain();

        // zero sizes act as one
        reg_write(REG_WIDTH, 0, SIZE_W);
        reg_write(REG_HEIGHT, 0, SIZE_W);
        bus_idle();
        send_pixel(0);
        send_pixel(1);
        drain();

        // oversize saturates to the maximum frame
        reg_write(REG_WIDTH, 2047, SIZE_W);
        reg_write(REG_HEIGHT, 1500, SIZE_W);
        reg_write(REG_TL, 32'hFFFFFF, RGB_W);
        reg_write(REG_BL, 32'h000000, RGB_W);
        reg_write(REG_TR, 32'h000000, RGB_W);
        reg_write(REG_BR, 32'hFFFFFF, RGB_W);
        bus_idle();
        send_pixel(0);
        send_pixel(1);
        send_pixel(0);
        drain();

        // small frame, then shrink mid-frame so column and row wrap
        reg_write(REG_WIDTH, 5, SIZE_W);
        reg_write(REG_HEIGHT, 3, SIZE_W);
        reg_write(REG_TL, 32'h12F0A5, RGB_W);
        reg_write(REG_BR, 32'hE00F5A, RGB_W);
        bus_idle();
        send_pixel(1);
        repeat (6) send_pixel(0);
        drain();
        reg_write(REG_WIDTH, 2, SIZE_W);
        reg_write(REG_HEIGHT, 1, SIZE_W);
        bus_idle();
        repeat (4) send_pixel(0);
        drain();

        random_start = sent;
        while (sent < random_start + RANDOM_PIXELS)
        begin
            random_phase();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bgg_pkg.sv
hw/rtl/bgg_regs.sv
hw/rtl/bgg_lerp_lane.sv
hw/rtl/bgg_datapath.sv
hw/rtl/bgg_ctrl.sv
hw/rtl/bilinear_gradient_generator.sv
bench/gradient_checker.sv
bench/tb.sv
